### hdl/sync_hunt_command_deframer_defines.svh
// Assertion macros for the serial command deframer.
// Depends on nothing; included by the files that carry assertions.
`ifndef SYNC_HUNT_COMMAND_DEFRAMER_DEFINES_SVH
`define SYNC_HUNT_COMMAND_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SHCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHCD_ASSERT_SAME(label, ante, cons, msg)
`define SHCD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/shcd_pkg.sv
// Package of the serial command deframer: pattern length, phase codes,
// result kinds and register indexes. Depends on nothing.
package shcd_pkg;

	localparam int SYNC_LEN = 4;
	localparam int MATCH_W = (SYNC_LEN > 1) ? $clog2(SYNC_LEN) : 1;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_CMD     = 3'd1;
	localparam logic [2:0] PH_ADDR_HI = 3'd2;
	localparam logic [2:0] PH_ADDR_LO = 3'd3;
	localparam logic [2:0] PH_LEN     = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	localparam logic [1:0] EV_ADDR_SET    = 2'd0;
	localparam logic [1:0] EV_PAYLOAD     = 2'd1;
	localparam logic [1:0] EV_EMPTY_SEND  = 2'd2;
	localparam logic [1:0] EV_UNKNOWN_CMD = 2'd3;

	localparam logic [1:0] CFG_SYNC_PATTERN = 2'd0;
	localparam logic [1:0] CFG_INIT_CODE    = 2'd1;
	localparam logic [1:0] CFG_SEND_CODE    = 2'd2;

	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

	typedef logic [7:0][7:0] pattern_t;

endpackage

### hdl/sync_hunt_command_deframer.sv
// Top level of the serial command deframer: pattern hunt, command decode
// and payload streaming. Depends on shcd_pkg and the assertion macro header.
//
// Usage: one received byte enters on rx_byte per input transaction
// (in_valid high, in_stall low at a rising edge). The block hunts for the
// SYNC_LEN byte start pattern, reads a command byte and its address and
// length bytes, and reports results on the output channel (out_valid high,
// out_stall low). A set-address command, an empty send and an unknown
// command each give one result; a send streams one result per payload byte
// with is_last on the final one. Pattern bytes give no result; a command,
// address or length byte gives one only when it ends the command.
// A result is written into the output register at the edge that accepts
// the input transaction that causes it. One byte is taken per cycle while
// the receiver does not stall; the whole decode is a single state update
// between the input and the output register.
// When the receiver stalls with a result held, in_stall is raised until
// that result is taken, and no input is lost.
// Reset (arst_n low) returns the block to hunting with an empty output
// register and the register defaults: pattern zero, init code 0, send
// code 1. Registers are written through cfg_valid/cfg_ready, always ready.
`include "sync_hunt_command_deframer_defines.svh"

module sync_hunt_command_deframer import shcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [15:0] node_address,
	output logic        is_broadcast,
	output logic [7:0]  payload_byte,
	output logic        is_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]        sync_pattern_q;
	logic [7:0]         init_code_q;
	logic [7:0]         send_code_q;
	logic [2:0]         phase_q;
	logic [MATCH_W-1:0] match_q;
	logic               cmd_send_q;
	logic [15:0]        addr_q;
	logic [7:0]         left_q;

	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [15:0]        out_addr_q;
	logic               bcast_q;
	logic [7:0]         pay_q;
	logic               last_q;

	logic               in_acc;
	pattern_t           pat_bytes;
	logic [MATCH_W-1:0] hunt_match;
	logic [7:0]         want;
	logic [7:0]         left_dec;

	logic [2:0]         phase_d;
	logic [MATCH_W-1:0] match_d;
	logic               cmd_send_d;
	logic [15:0]        addr_d;
	logic [7:0]         left_d;
	logic               res_valid;
	logic [1:0]         res_kind;
	logic [15:0]        res_addr;
	logic [7:0]         res_pay;
	logic               res_last;

	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	assign pat_bytes  = sync_pattern_q;
	assign hunt_match = (phase_q == PH_HUNT) ? match_q : '0;
	assign want       = pat_bytes[3'(hunt_match)];
	assign left_dec   = left_q - 8'd1;

	always_comb begin
		phase_d    = phase_q;
		match_d    = match_q;
		cmd_send_d = cmd_send_q;
		addr_d     = addr_q;
		left_d     = left_q;
		res_valid  = 1'b0;
		res_kind   = EV_ADDR_SET;
		res_addr   = addr_q;
		res_pay    = 8'd0;
		res_last   = 1'b1;
		unique case (phase_q)
			PH_CMD: begin
				if (rx_byte == init_code_q) begin
					cmd_send_d = 1'b0;
					phase_d    = PH_ADDR_HI;
				end else if (rx_byte == send_code_q) begin
					cmd_send_d = 1'b1;
					phase_d    = PH_ADDR_HI;
				end else begin
					phase_d   = PH_HUNT;
					match_d   = '0;
					res_valid = 1'b1;
					res_kind  = EV_UNKNOWN_CMD;
					res_addr  = 16'd0;
				end
			end
			PH_ADDR_HI: begin
				addr_d  = {rx_byte, addr_q[7:0]};
				phase_d = PH_ADDR_LO;
			end
			PH_ADDR_LO: begin
				addr_d   = {addr_q[15:8], rx_byte};
				res_addr = {addr_q[15:8], rx_byte};
				if (!cmd_send_q) begin
					phase_d   = PH_HUNT;
					match_d   = '0;
					res_valid = 1'b1;
					res_kind  = EV_ADDR_SET;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				left_d = rx_byte;
				if (rx_byte == 8'd0) begin
					phase_d   = PH_HUNT;
					match_d   = '0;
					res_valid = 1'b1;
					res_kind  = EV_EMPTY_SEND;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				left_d    = left_dec;
				res_valid = 1'b1;
				res_kind  = EV_PAYLOAD;
				res_pay   = rx_byte;
				res_last  = (left_dec == 8'd0);
				if (left_dec == 8'd0) begin
					phase_d = PH_HUNT;
					match_d = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == want) begin
					if (hunt_match == MATCH_W'(SYNC_LEN - 1)) begin
						match_d = '0;
						phase_d = PH_CMD;
					end else begin
						match_d = hunt_match + MATCH_W'(1);
					end
				end else begin
					match_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= 64'd0;
			init_code_q    <= 8'd0;
			send_code_q    <= 8'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SYNC_PATTERN: sync_pattern_q <= cfg_data;
				CFG_INIT_CODE:    init_code_q    <= cfg_data[7:0];
				CFG_SEND_CODE:    send_code_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			match_q    <= '0;
			cmd_send_q <= 1'b0;
			addr_q     <= 16'd0;
			left_q     <= 8'd0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			match_q    <= match_d;
			cmd_send_q <= cmd_send_d;
			addr_q     <= addr_d;
			left_q     <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= in_acc & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			kind_q     <= res_kind;
			out_addr_q <= res_addr;
			bcast_q    <= (res_kind != EV_UNKNOWN_CMD) &&
			              (res_addr == {BYTE_ALL_ONES, BYTE_ALL_ONES});
			pay_q      <= res_pay;
			last_q     <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign node_address = out_addr_q;
	assign is_broadcast = bcast_q;
	assign payload_byte = pay_q;
	assign is_last      = last_q;

	`SHCD_ASSERT_SAME(a_match_only_hunting, match_q != '0, phase_q == PH_HUNT, "match index set outside hunt")
	`SHCD_ASSERT_SAME(a_payload_count, phase_q == PH_PAYLOAD, left_q != 8'd0, "payload phase with zero count")
	`SHCD_ASSERT_NEXT(a_payload_result, in_acc && phase_q == PH_PAYLOAD, out_valid_q, "payload byte gave no result")

endmodule
